FILE: rtl/counts_to_brightness_temp_macros.svh
// Assertion helpers for the RTL
`ifndef COUNTS_TO_BRIGHTNESS_TEMP_MACROS_SVH
`define COUNTS_TO_BRIGHTNESS_TEMP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define C2BT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication after the delay given by dly, disabled during reset
`define C2BT_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

FILE: rtl/c2bt_pkg.sv
package c2bt_pkg;

  localparam int RAW_W          = 10;
  localparam int COUNT_BITS_DEF = 10;
  localparam int LOG_STEPS      = 30;
  localparam int QBITS          = 41;

  localparam logic [31:0] C1_MANT   = 32'd3352479563;
  localparam logic [31:0] C2_Q30    = 32'd1544867524;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] ALPHA_RST = 32'h4000_0000;
  localparam logic [40:0] QUOT_MAX  = 41'h100_0000_0000;
  localparam logic [37:0] DIFF_MAX  = 38'h3F_FFFF_FFFF;

  // register indexes on the configuration port
  localparam logic [2:0] REG_SLOPE  = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_NU     = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_BETA   = 3'd4;

  typedef struct packed {
    logic [RAW_W-1:0] raw_count;
    logic             last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic               invalid;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic bad;
    logic last;
  } side_t;

endpackage

FILE: rtl/counts_to_brightness_temp.sv
// Throughput: one word per cycle; busy is never raised.
// The depth is set by the 30-step log2 squaring chain and the 41-step divider.
// Reset clears all valid bits (words in flight are dropped) and restores register defaults.
// Results cannot be held off by the receiver, so the pipeline never stalls.
`include "counts_to_brightness_temp_macros.svh"
module counts_to_brightness_temp #(
  parameter int COUNT_BITS = c2bt_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  c2bt_pkg::in_word_t  item,
  output logic                done,
  output c2bt_pkg::out_word_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import c2bt_pkg::*;

  localparam int DEPTH = 8 + LOG_STEPS + 4 + QBITS;
  localparam int LAT   = DEPTH + 1;
  localparam logic [RAW_W-1:0] CNT_MASK = (COUNT_BITS >= RAW_W) ? {RAW_W{1'b1}}
                                          : RAW_W'((1 << COUNT_BITS) - 1);

  function automatic logic [6:0] lead_zeros(input logic [63:0] m);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // configuration registers
  logic [31:0] calib_slope, calib_offset, wavenumber, band_alpha, band_beta;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_slope  <= '0;
      calib_offset <= '0;
      wavenumber   <= '0;
      band_alpha   <= ALPHA_RST;
      band_beta    <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SLOPE:  calib_slope  <= pwdata;
        REG_OFFSET: calib_offset <= pwdata;
        REG_NU:     wavenumber   <= pwdata;
        REG_ALPHA:  band_alpha   <= pwdata;
        REG_BETA:   band_beta    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SLOPE:  prdata = calib_slope;
      REG_OFFSET: prdata = calib_offset;
      REG_NU:     prdata = wavenumber;
      REG_ALPHA:  prdata = band_alpha;
      REG_BETA:   prdata = band_beta;
      default:    prdata = '0;
    endcase
  end

  // valid bits and side data
  logic  accept;
  logic  vl [DEPTH];
  side_t sd [DEPTH];

  // stage 1: linear calibration and nu squared
  logic [RAW_W-1:0]   cnt;
  logic signed [49:0] slope_x, cnt_x, off_x, rad_c;
  logic               rad_pos;

  assign accept  = start && !busy;
  assign cnt     = item.raw_count & CNT_MASK;
  assign slope_x = 50'($signed(calib_slope));
  assign cnt_x   = $signed({40'd0, cnt});
  assign off_x   = 50'($signed(calib_offset));
  assign rad_c   = 50'(slope_x * cnt_x) + (off_x <<< 8);
  assign rad_pos = !rad_c[49] && (rad_c != 50'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vl[k] <= 1'b0;
    end else begin
      vl[0] <= accept;
      for (int k = 1; k < DEPTH; k++) vl[k] <= vl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= '{bad: !rad_pos, last: item.last_in};
    for (int k = 1; k < DEPTH; k++) sd[k] <= sd[k-1];
  end

  logic [49:0] s1_rad;
  logic [63:0] s1_nn;
  always_ff @(posedge clk) begin
    s1_rad <= rad_c;
    s1_nn  <= 64'(wavenumber) * 64'(wavenumber);
  end

  // stage 2: fit nu^2 to 32 bits, form c2*nu
  logic [6:0]        lz2, bl2, k2;
  logic [31:0]       s2_a;
  logic signed [7:0] s2_e;
  logic [49:0]       s2_bm;
  logic [63:0]       s2_num;
  always_comb begin
    lz2 = lead_zeros(s1_nn);
    bl2 = 7'd64 - lz2;
    k2  = (bl2 > 7'd32) ? bl2 - 7'd32 : 7'd0;
  end
  always_ff @(posedge clk) begin
    s2_a   <= 32'(s1_nn >> k2);
    s2_e   <= -8'sd32 + $signed({1'b0, k2});
    s2_bm  <= s1_rad;
    s2_num <= 64'(C2_Q30) * 64'(wavenumber);
  end

  // stage 3: times nu
  logic [63:0]       s3_p;
  logic signed [7:0] s3_e;
  logic [49:0]       s3_bm;
  logic [63:0]       s3_num;
  always_ff @(posedge clk) begin
    s3_p   <= 64'(s2_a) * 64'(wavenumber);
    s3_e   <= s2_e - 8'sd16;
    s3_bm  <= s2_bm;
    s3_num <= s2_num;
  end

  // stage 4: fit to 32 bits
  logic [6:0]        lz4, bl4, k4;
  logic [31:0]       s4_a;
  logic signed [7:0] s4_e;
  logic [49:0]       s4_bm;
  logic [63:0]       s4_num;
  always_comb begin
    lz4 = lead_zeros(s3_p);
    bl4 = 7'd64 - lz4;
    k4  = (bl4 > 7'd32) ? bl4 - 7'd32 : 7'd0;
  end
  always_ff @(posedge clk) begin
    s4_a   <= 32'(s3_p >> k4);
    s4_e   <= s3_e + $signed({1'b0, k4});
    s4_bm  <= s3_bm;
    s4_num <= s3_num;
  end

  // stage 5: times c1
  logic [63:0]       s5_p;
  logic signed [7:0] s5_e;
  logic [49:0]       s5_bm;
  logic [63:0]       s5_num;
  always_ff @(posedge clk) begin
    s5_p   <= 64'(s4_a) * 64'(C1_MANT);
    s5_e   <= s4_e - 8'sd48;
    s5_bm  <= s4_bm;
    s5_num <= s4_num;
  end

  // stage 6: fit to 62 bits
  logic [6:0]        lz6, bl6, k6;
  logic [61:0]       s6_a;
  logic signed [7:0] s6_e;
  logic [49:0]       s6_bm;
  logic [63:0]       s6_num;
  always_comb begin
    lz6 = lead_zeros(s5_p);
    bl6 = 7'd64 - lz6;
    k6  = (bl6 > 7'd62) ? bl6 - 7'd62 : 7'd0;
  end
  always_ff @(posedge clk) begin
    s6_a   <= 62'(s5_p >> k6);
    s6_e   <= s5_e + $signed({1'b0, k6});
    s6_bm  <= s5_bm;
    s6_num <= s5_num;
  end

  // stage 7: align and add radiance to c1*nu^3
  logic [63:0]       bm64, a64, sm_c;
  logic [7:0]        dsh;
  logic signed [7:0] se_c;
  logic [63:0]       s7_sm, s7_bm;
  logic signed [7:0] s7_e;
  logic [63:0]       s7_num;
  always_comb begin
    bm64 = {14'd0, s6_bm};
    a64  = {2'd0, s6_a};
    dsh  = '0;
    if (s6_a == 62'd0) begin
      sm_c = bm64;
      se_c = -8'sd24;
    end else if (s6_e >= -8'sd24) begin
      dsh  = 8'(s6_e + 8'sd24);
      sm_c = a64 + ((dsh[7:6] == 2'd0) ? (bm64 >> dsh[5:0]) : 64'd0);
      se_c = s6_e;
    end else begin
      dsh  = 8'(-8'sd24 - s6_e);
      sm_c = bm64 + ((dsh[7:6] == 2'd0) ? (a64 >> dsh[5:0]) : 64'd0);
      se_c = -8'sd24;
    end
  end
  always_ff @(posedge clk) begin
    s7_sm  <= sm_c;
    s7_e   <= se_c;
    s7_bm  <= bm64;
    s7_num <= s6_num;
  end

  // stage 8: normalise both log operands; lanes index 0
  logic [31:0]       lg_ys  [LOG_STEPS+1];
  logic [31:0]       lg_yb  [LOG_STEPS+1];
  logic [29:0]       lg_fs  [LOG_STEPS+1];
  logic [29:0]       lg_fb  [LOG_STEPS+1];
  logic signed [9:0] lg_int [LOG_STEPS+1];
  logic [63:0]       lg_num [LOG_STEPS+1];
  logic [6:0]        lzs, lzb;
  logic [63:0]       ns, nb;
  always_comb begin
    lzs = lead_zeros(s7_sm);
    lzb = lead_zeros(s7_bm);
    ns  = s7_sm << lzs[5:0];
    nb  = s7_bm << lzb[5:0];
  end
  always_ff @(posedge clk) begin
    lg_ys[0]  <= ns[63:32];
    lg_yb[0]  <= nb[63:32];
    lg_fs[0]  <= '0;
    lg_fb[0]  <= '0;
    lg_int[0] <= $signed({3'd0, lzb}) - $signed({3'd0, lzs}) + 10'(s7_e) + 10'sd24;
    lg_num[0] <= s7_num;
  end

  // stages 9..38: one squaring step per stage in each lane
  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    logic [63:0] sqs, sqb;
    logic [32:0] ts, tb;
    always_comb begin
      sqs = 64'(lg_ys[j]) * 64'(lg_ys[j]);
      sqb = 64'(lg_yb[j]) * 64'(lg_yb[j]);
      ts  = sqs[63:31];
      tb  = sqb[63:31];
    end
    always_ff @(posedge clk) begin
      lg_ys[j+1]  <= ts[32] ? ts[32:1] : ts[31:0];
      lg_yb[j+1]  <= tb[32] ? tb[32:1] : tb[31:0];
      lg_fs[j+1]  <= {lg_fs[j][28:0], ts[32]};
      lg_fb[j+1]  <= {lg_fb[j][28:0], tb[32]};
      lg_int[j+1] <= lg_int[j];
      lg_num[j+1] <= lg_num[j];
    end
  end

  // stage 39: log2 difference with clamping
  logic signed [41:0] dfull;
  logic [37:0]        s39_d;
  logic [63:0]        s39_num;
  assign dfull = {{2{lg_int[LOG_STEPS][9]}}, lg_int[LOG_STEPS], 30'd0}
               + {12'd0, lg_fs[LOG_STEPS]} - {12'd0, lg_fb[LOG_STEPS]};
  always_ff @(posedge clk) begin
    if (dfull[41])                s39_d <= '0;
    else if (dfull[40:38] != 3'd0) s39_d <= DIFF_MAX;
    else                          s39_d <= dfull[37:0];
    s39_num <= lg_num[LOG_STEPS];
  end

  // stage 40: convert to natural log
  logic [63:0] lnp;
  logic [31:0] s40_ln;
  logic [63:0] s40_num;
  assign lnp = 64'(s39_d[37:6]) * 64'(LN2_Q32);
  always_ff @(posedge clk) begin
    s40_ln  <= lnp[63:32];
    s40_num <= s39_num;
  end

  // stage 41: band multiplier
  logic [63:0] denp;
  logic [39:0] s41_den;
  logic [63:0] s41_num;
  assign denp = 64'(band_alpha) * 64'(s40_ln);
  always_ff @(posedge clk) begin
    s41_den <= denp[63:24];
    s41_num <= s40_num;
  end

  // stage 42: divider set-up and overflow check; divider index 0
  logic [40:0] dv_r   [QBITS+1];
  logic [40:0] dv_nl  [QBITS+1];
  logic [40:0] dv_q   [QBITS+1];
  logic [39:0] dv_den [QBITS+1];
  logic        dv_ovf [QBITS+1];
  always_ff @(posedge clk) begin
    dv_r[0]   <= {19'd0, s41_num[62:41]};
    dv_nl[0]  <= s41_num[40:0];
    dv_q[0]   <= '0;
    dv_den[0] <= s41_den;
    dv_ovf[0] <= (s41_den == 40'd0) || ({18'd0, s41_num[62:41]} >= s41_den);
  end

  // stages 43..83: one restoring quotient bit per stage
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    logic [40:0] rt, dx;
    logic        ge;
    always_comb begin
      rt = {dv_r[j][39:0], dv_nl[j][40]};
      dx = {1'b0, dv_den[j]};
      ge = (rt >= dx);
    end
    always_ff @(posedge clk) begin
      dv_r[j+1]   <= ge ? rt - dx : rt;
      dv_q[j+1]   <= {dv_q[j][39:0], ge};
      dv_nl[j+1]  <= {dv_nl[j][39:0], 1'b0};
      dv_den[j+1] <= dv_den[j];
      dv_ovf[j+1] <= dv_ovf[j];
    end
  end

  // output stage: cap, subtract band offset, saturate, zero invalid words
  logic [40:0]        quot;
  logic signed [23:0] beta16;
  logic signed [42:0] bt;
  logic signed [31:0] bt_sat;
  always_comb begin
    quot   = (dv_ovf[QBITS] || dv_q[QBITS] > QUOT_MAX) ? QUOT_MAX : dv_q[QBITS];
    beta16 = 24'($signed(band_beta) >>> 8);
    bt     = $signed({2'b00, quot}) - 43'(beta16);
    if (bt > 43'sd2147483647)       bt_sat = 32'sh7FFF_FFFF;
    else if (bt < -43'sd2147483648) bt_sat = 32'sh8000_0000;
    else                            bt_sat = bt[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vl[DEPTH-1];
  end

  always_ff @(posedge clk) begin
    result.temperature <= sd[DEPTH-1].bad ? 32'sd0 : bt_sat;
    result.invalid     <= sd[DEPTH-1].bad;
    result.last_out    <= sd[DEPTH-1].last;
  end

  `C2BT_ASSERT_DLY(a_latency, accept, LAT, done, "accepted word did not complete on time")
  `C2BT_ASSERT_DLY(a_bad_flag, accept && !rad_pos, LAT, done && result.invalid, "bad radiance lost")
  `C2BT_ASSERT_IMP(a_invalid_zero, done && result.invalid, result.temperature == 32'sd0, "invalid not zero")
  `C2BT_ASSERT_IMP(a_floor, done && !result.invalid, result.temperature > -32'sd8388608, "below floor")

endmodule

FILE: verif/counts_to_brightness_temp_tb.sv
module counts_to_brightness_temp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c2bt_pkg::*;

  localparam int  CNT_BITS   = COUNT_BITS_DEF;
  localparam int  TAIL_WAIT  = 100;
  localparam int  CYCLE_CAP  = 400000;

  // Tracks the per-channel registers and the temperatures still due from the block
  class temp_scoreboard;
    logic [31:0] regs [5];
    out_word_t   pending [$];
    int          errors;
    int          n_checked;
    int          n_invalid;
    int          n_sat_high;

    function new();
      regs[REG_SLOPE]  = '0;
      regs[REG_OFFSET] = '0;
      regs[REG_NU]     = '0;
      regs[REG_ALPHA]  = ALPHA_RST;
      regs[REG_BETA]   = '0;
      errors = 0;
      n_checked = 0;
      n_invalid = 0;
      n_sat_high = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      regs[idx] = val;
    endfunction

    // Shift the mantissa down until it fits, bumping the exponent
    function void squeeze(ref longint unsigned m, ref int e, input int bits);
      while ((m >> bits) != 0) begin
        m = m >> 1;
        e++;
      end
    endfunction

    // Base-2 log of m * 2^e in Q30 by repeated squaring
    function longint log2_fix(longint unsigned m, int e);
      int p;
      longint unsigned y;
      longint frac;
      p = 63;
      frac = 0;
      while (p > 0 && m[p] == 1'b0) p--;
      y = (p >= 31) ? (m >> (p - 31)) : (m << (31 - p));
      for (int i = 29; i >= 0; i--) begin
        y = (y * y) >> 31;
        if (y >= (64'd1 << 32)) begin
          y = y >> 1;
          frac = frac | (64'sd1 << i);
        end
      end
      return longint'(p + e) * (64'sd1 << 30) + frac;
    endfunction

    // Calibrate the count and run the inverse Planck conversion
    function out_word_t brightness_of(in_word_t w);
      longint unsigned cnt, nu, am, bm, sm, lnq, den, num, quot;
      int ae, be, se, d;
      longint rad, diff, bt, beta16;
      out_word_t r;
      cnt = 64'(w.raw_count) & ((64'd1 << CNT_BITS) - 1);
      rad = longint'(signed'(regs[REG_SLOPE])) * longint'(cnt)
          + longint'(signed'(regs[REG_OFFSET])) * 256;
      r.last_out = w.last_in;
      if (rad <= 0) begin
        r.temperature = '0;
        r.invalid = 1'b1;
        return r;
      end
      nu = 64'(regs[REG_NU]);
      am = nu * nu;
      ae = -32;
      squeeze(am, ae, 32);
      am = am * nu;
      ae -= 16;
      squeeze(am, ae, 32);
      am = am * 64'(C1_MANT);
      ae -= 48;
      squeeze(am, ae, 62);
      bm = longint'(rad);
      be = -24;
      if (am == 0) begin
        sm = bm;
        se = be;
      end else if (ae >= be) begin
        d = ae - be;
        sm = am + ((d < 64) ? (bm >> d) : 64'd0);
        se = ae;
      end else begin
        d = be - ae;
        sm = bm + ((d < 64) ? (am >> d) : 64'd0);
        se = be;
      end
      diff = log2_fix(sm, se) - log2_fix(bm, be);
      if (diff < 0) diff = 0;
      if (diff > longint'(DIFF_MAX)) diff = longint'(DIFF_MAX);
      lnq = ((longint'(diff) >> 6) * 64'(LN2_Q32)) >> 32;
      den = (64'(regs[REG_ALPHA]) * lnq) >> 24;
      num = 64'(C2_Q30) * nu;
      quot = (den != 0) ? (num / den) : 64'(QUOT_MAX);
      if (quot > 64'(QUOT_MAX)) quot = 64'(QUOT_MAX);
      beta16 = longint'(signed'(regs[REG_BETA])) >>> 8;
      bt = longint'(quot) - beta16;
      if (bt > 64'sd2147483647) bt = 64'sd2147483647;
      if (bt < -64'sd2147483648) bt = -64'sd2147483648;
      r.temperature = bt[31:0];
      r.invalid = 1'b0;
      return r;
    endfunction

    function void note_count(in_word_t w);
      pending.push_back(brightness_of(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      n_checked++;
      if (exp_w.invalid) n_invalid++;
      if (exp_w.temperature == 32'sh7FFF_FFFF) n_sat_high++;
      if (got.temperature !== exp_w.temperature) begin
        $display("%0t: temperature expected %h actual %h", $realtime,
                 exp_w.temperature, got.temperature);
        errors++;
      end
      if (got.invalid !== exp_w.invalid) begin
        $display("%0t: invalid expected %b actual %b", $realtime,
                 exp_w.invalid, got.invalid);
        errors++;
      end
      if (got.last_out !== exp_w.last_out) begin
        $display("%0t: last_out expected %b actual %b", $realtime,
                 exp_w.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    item;
  logic        done;
  out_word_t   result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  temp_scoreboard sb;
  int unsigned    cycles;
  int             n_sent;
  bit             no_gaps;

  counts_to_brightness_temp u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  // Note accepted counts and check strobed temperatures
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_count(item);
      if (done) sb.check_result(result);
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL counts_to_brightness_temp");
      $finish;
    end
  end

  // Write one register through a setup and an access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop start, hold off until every temperature has come back, then settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_channel(logic [31:0] s, logic [31:0] o, logic [31:0] n,
                              logic [31:0] a, logic [31:0] b);
    drain();
    write_reg(REG_SLOPE, s);
    write_reg(REG_OFFSET, o);
    write_reg(REG_NU, n);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    @(posedge clk);
  endtask

  // Present one word, hold it until taken, then maybe idle
  task automatic send_count(logic [RAW_W-1:0] c, logic l);
    int r, gap;
    start <= 1'b1;
    item  <= '{raw_count: c, last_in: l};
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    r = $urandom_range(0, 99);
    gap = (no_gaps || r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Random counts with last_in set at random, then idle
  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send_count($urandom_range(0, 1023), ($urandom_range(0, 15) == 0));
    idle_start();
  endtask

  initial begin
    logic [31:0] v [5];
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    n_sent = 0;
    no_gaps = 1'b0;
    sb = new();
    start   <= 1'b0;
    item    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: zero radiance everywhere, so every word is invalid
    send_count(10'd0, 1'b0);
    send_count(10'd1023, 1'b1);
    idle_start();

    // Typical infrared channel: 930 cm-1, gain 0.2, offset -10
    load_channel(32'h0033_3333, 32'hFFF6_0000, 32'd930 << 16, 32'h4000_0000,
                 32'h0080_0000);
    send_count(10'd0, 1'b0);
    send_count(10'd1, 1'b0);
    send_count(10'd50, 1'b0);
    send_count(10'd51, 1'b0);
    send_count(10'd512, 1'b0);
    send_count(10'd1023, 1'b1);
    idle_start();

    // Zero wavenumber and zero alpha saturate the temperature high
    load_channel(32'h0100_0000, 32'h0001_0000, 32'd0, 32'h4000_0000, 32'h0);
    send_count(10'd7, 1'b0);
    send_count(10'd1023, 1'b1);
    load_channel(32'h0100_0000, 32'h0001_0000, 32'd930 << 16, 32'd0, 32'hFF00_0000);
    send_count(10'd300, 1'b1);
    // Huge log ratio: tiny radiance, high wavenumber
    load_channel(32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_count(10'd1, 1'b0);
    send_count(10'd1023, 1'b1);
    // Tiny wavenumber against huge radiance leaves the log unresolved
    load_channel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'h4000_0000, 32'h7FFF_FFFF);
    send_count(10'd0, 1'b0);
    send_count(10'd1023, 1'b1);
    // Most negative registers: radiance never positive
    load_channel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
    send_count(10'd1023, 1'b0);
    send_count(10'd0, 1'b1);
    idle_start();

    // Realistic channels with random content, first without idling
    for (int ph = 0; ph < 8; ph++) begin
      load_channel($urandom_range(32'h0001_0000, 32'h0100_0000),
                   32'hFFF0_0000 + $urandom_range(0, 32'h0020_0000),
                   $urandom_range(600, 3000) << 16,
                   $urandom_range(32'h3C00_0000, 32'h4400_0000),
                   $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
      no_gaps = (ph < 2);
      random_run(110);
    end
    no_gaps = 1'b0;

    // Fully random registers for the remainder
    for (int ph = 0; ph < 4; ph++) begin
      foreach (v[k]) v[k] = $urandom();
      load_channel(v[0], v[1], v[2], v[3], v[4]);
      random_run(100);
    end

    // Restore the typical channel for a final burst
    load_channel(32'h0033_3333, 32'hFFF6_0000, 32'd930 << 16, 32'h4000_0000,
                 32'h0080_0000);
    random_run(30);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d counts over %0d register settings; %0d temperatures checked",
             n_sent, 20, sb.n_checked);
    $display("%0d flagged invalid, %0d saturated high, %0d errors",
             sb.n_invalid, sb.n_sat_high, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS counts_to_brightness_temp");
    end else begin
      $display("FAIL counts_to_brightness_temp");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/c2bt_pkg.sv
rtl/counts_to_brightness_temp.sv
verif/counts_to_brightness_temp_tb.sv
